@@ rtl/core/rbfk_pkg.sv @@
// ----------------------------------------------------------------------------
// rbfk_pkg
// Shared types and constants for the Gaussian RBF kernel block.
// ----------------------------------------------------------------------------
package rbfk_pkg;

    localparam int MAX_ELEMENTS = 1024;
    localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
    localparam int DIST_W       = 42;
    localparam int X_W          = 58;

    localparam logic [DIST_W-1:0] ACC_MAX   = {DIST_W{1'b1}};
    localparam logic [X_W-1:0]    LN2_Q32   = 58'h0_0000_B172_17F8;
    localparam logic [X_W-1:0]    X_LIMIT   = 58'd12 << 32;
    localparam logic [30:0]       ONE_Q30   = 31'h4000_0000;
    localparam logic [3:0]        LAST_TERM = 4'd14;
    localparam logic [15:0]       GAMMA_RST = 16'd256;

    typedef logic [DIST_W-1:0] dist_t;

    typedef enum logic [12:0] {
        S_IDLE    = 13'b0_0000_0000_0001,
        S_MUL_LO  = 13'b0_0000_0000_0010,
        S_MUL_HI  = 13'b0_0000_0000_0100,
        S_CHECK   = 13'b0_0000_0000_1000,
        S_RANGE   = 13'b0_0000_0001_0000,
        S_TMUL_LO = 13'b0_0000_0010_0000,
        S_TMUL_HI = 13'b0_0000_0100_0000,
        S_RMUL_LO = 13'b0_0000_1000_0000,
        S_RMUL_HI = 13'b0_0001_0000_0000,
        S_ACCUM   = 13'b0_0010_0000_0000,
        S_SCALE   = 13'b0_0100_0000_0000,
        S_DMUL_LO = 13'b0_1000_0000_0000,
        S_DMUL_HI = 13'b1_0000_0000_0000
    } back_state_t;

    typedef struct packed {
        logic  push;
        dist_t dist2;
    } q_wr_t;

    typedef struct packed {
        logic  valid;
        dist_t dist2;
    } q_rd_t;

endpackage

@@ rtl/core/rbfk_if.sv @@
// ----------------------------------------------------------------------------
// rbfk_if
// Valid/ready channels of the RBF kernel block.
// ----------------------------------------------------------------------------
interface rbfk_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] a_elem;
    logic signed [15:0] b_elem;
    logic               last;
    modport source (output valid, a_elem, b_elem, last, input ready);
    modport sink   (input valid, a_elem, b_elem, last, output ready);
endinterface

interface rbfk_out_if;
    logic               valid;
    logic               ready;
    logic        [15:0] kernel_value;
    logic signed [42:0] gamma_derivative;
    modport source (output valid, kernel_value, gamma_derivative, input ready);
    modport sink   (input valid, kernel_value, gamma_derivative, output ready);
endinterface

interface rbfk_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

@@ rtl/core/rbf_kernel_with_gradient.sv @@
// ----------------------------------------------------------------------------
// rbf_kernel_with_gradient
// Gaussian RBF kernel exp(-gamma*||a-b||^2) and its derivative in gamma.
//
//  channel  dir  beat                          notes
//  in_ch    in   a_elem, b_elem, last          one element pair per beat
//  out_ch   out  kernel_value, gamma_derivative one beat per vector pair
//  cfg      in   data (gamma, UQ0.32)          always ready
//
// Pairs are taken one per cycle while the queue is not full; the sum of
// squares is done in the front. The back sequencer reduces its argument
// by ln2 (n <= 17 reduction steps) and skips the series when the exponent
// is out of range; each of the 14 Taylor terms is a two-step multiply, a
// two-step reciprocal multiply for the divide by k, and an accumulate.
// A two-entry queue lets the front keep accepting while the back works;
// in_ch stalls only when that queue is full. No clearing pass after reset.
// ----------------------------------------------------------------------------
module rbf_kernel_with_gradient (
    input  logic        clk,
    input  logic        rst_n,
    rbfk_in_if.sink     in_ch,
    rbfk_out_if.source  out_ch,
    rbfk_cfg_if.sink    cfg
);

    rbfk_pkg::q_wr_t q_wr;
    rbfk_pkg::q_rd_t q_rd;
    logic            q_full;
    logic            pop;

    rbfk_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .q_full (q_full),
        .q_wr   (q_wr)
    );

    rbfk_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .q_wr  (q_wr),
        .pop   (pop),
        .full  (q_full),
        .q_rd  (q_rd)
    );

    rbfk_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .q_rd   (q_rd),
        .pop    (pop),
        .out_ch (out_ch)
    );

endmodule

@@ rtl/core/rbfk_front.sv @@
// ----------------------------------------------------------------------------
// rbfk_front
// Accepts element pairs, accumulates squared distance, queues it on last.
// ----------------------------------------------------------------------------
module rbfk_front (
    input  logic           clk,
    input  logic           rst_n,
    rbfk_in_if.sink        in_ch,
    input  logic           q_full,
    output rbfk_pkg::q_wr_t q_wr
);

    logic [rbfk_pkg::DIST_W-1:0] acc_reg, acc_next;
    logic [rbfk_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic signed [16:0]          diff;
    logic signed [33:0]          sq_s;
    logic [31:0]                 sq;
    logic [rbfk_pkg::DIST_W:0]   sum;
    logic [rbfk_pkg::DIST_W-1:0] acc_upd;
    logic                        beat;

    assign in_ch.ready = !q_full;
    assign beat        = in_ch.valid && in_ch.ready;

    always_comb
    begin
        diff = 17'(in_ch.a_elem) - 17'(in_ch.b_elem);
        sq_s = diff * diff;
        sq   = sq_s[31:0];
        sum  = {1'b0, acc_reg} + {11'b0, sq};
        if (cnt_reg < rbfk_pkg::CNT_W'(rbfk_pkg::MAX_ELEMENTS))
        begin
            acc_upd  = sum[rbfk_pkg::DIST_W] ? rbfk_pkg::ACC_MAX : sum[rbfk_pkg::DIST_W-1:0];
            cnt_next = cnt_reg + 1'b1;
        end
        else
        begin
            acc_upd  = acc_reg;
            cnt_next = cnt_reg;
        end
        acc_next   = acc_reg;
        q_wr.push  = 1'b0;
        q_wr.dist2 = acc_upd;
        if (beat)
        begin
            if (in_ch.last)
            begin
                q_wr.push = 1'b1;
                acc_next  = '0;
                cnt_next  = '0;
            end
            else
            begin
                acc_next = acc_upd;
            end
        end
        else
        begin
            cnt_next = cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

@@ rtl/core/rbfk_queue.sv @@
// ----------------------------------------------------------------------------
// rbfk_queue
// Two-entry queue of finished squared distances between front and back.
// ----------------------------------------------------------------------------
module rbfk_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  rbfk_pkg::q_wr_t q_wr,
    input  logic            pop,
    output logic            full,
    output rbfk_pkg::q_rd_t q_rd
);

    rbfk_pkg::dist_t mem_reg [2];
    logic            wp_reg, wp_next;
    logic            rp_reg, rp_next;
    logic [1:0]      cnt_reg, cnt_next;
    logic            do_pop;

    assign full       = (cnt_reg == 2'd2);
    assign q_rd.valid = (cnt_reg != 2'd0);
    assign q_rd.dist2 = mem_reg[rp_reg];
    assign do_pop     = pop && q_rd.valid;

    always_comb
    begin
        wp_next  = q_wr.push ? !wp_reg : wp_reg;
        rp_next  = do_pop ? !rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, q_wr.push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (q_wr.push)
        begin
            mem_reg[wp_reg] <= q_wr.dist2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

@@ rtl/core/rbfk_back.sv @@
// ----------------------------------------------------------------------------
// rbfk_back
// Sequencer: exp(-gamma*dist2) by ln2 range reduction and Taylor series,
// then the gamma derivative. One shared 31x21 multiplier; the divide by the
// term index is a multiply by a rounded-up reciprocal, exact for 31-bit terms.
// ----------------------------------------------------------------------------
module rbfk_back (
    input  logic            clk,
    input  logic            rst_n,
    rbfk_cfg_if.sink        cfg,
    input  rbfk_pkg::q_rd_t q_rd,
    output logic            pop,
    rbfk_out_if.source      out_ch
);

    rbfk_pkg::back_state_t state_reg, state_next;

    logic [15:0]                 gamma_reg;
    logic [rbfk_pkg::DIST_W-1:0] dist_reg, dist_next;
    logic [rbfk_pkg::X_W-1:0]    x_reg, x_next;
    logic [51:0]                 prod_reg, prod_next;
    logic [4:0]                  n_reg, n_next;
    logic [29:0]                 r30_reg, r30_next;
    logic [30:0]                 term_reg, term_next;
    logic [30:0]                 quot_reg, quot_next;
    logic [3:0]                  k_reg, k_next;
    logic signed [32:0]          sum_reg, sum_next;
    logic [15:0]                 kv_reg, kv_next;
    logic                        ov_reg, ov_next;
    logic [15:0]                 okv_reg, okv_next;
    logic signed [42:0]          oder_reg, oder_next;

    logic [30:0] mul_a;
    logic [20:0] mul_b;
    logic [51:0] mul_p;
    logic [35:0] recip;
    logic [60:0] tfull;
    logic [66:0] qfull;
    logic [57:0] dfull;
    logic [31:0] sum_pos;
    logic [5:0]  sh;
    logic [47:0] rnd;

    // ceil(2^35 / k)
    function automatic logic [35:0] recip_of(input logic [3:0] k);
        case (k)
            4'd1:    recip_of = 36'h8_0000_0000;
            4'd2:    recip_of = 36'h4_0000_0000;
            4'd3:    recip_of = 36'h2_AAAA_AAAB;
            4'd4:    recip_of = 36'h2_0000_0000;
            4'd5:    recip_of = 36'h1_9999_999A;
            4'd6:    recip_of = 36'h1_5555_5556;
            4'd7:    recip_of = 36'h1_2492_4925;
            4'd8:    recip_of = 36'h1_0000_0000;
            4'd9:    recip_of = 36'h0_E38E_38E4;
            4'd10:   recip_of = 36'h0_CCCC_CCCD;
            4'd11:   recip_of = 36'h0_BA2E_8BA3;
            4'd12:   recip_of = 36'h0_AAAA_AAAB;
            4'd13:   recip_of = 36'h0_9D89_D89E;
            4'd14:   recip_of = 36'h0_9249_2493;
            default: recip_of = '0;
        endcase
    endfunction

    assign cfg.ready               = 1'b1;
    assign out_ch.valid            = ov_reg;
    assign out_ch.kernel_value     = okv_reg;
    assign out_ch.gamma_derivative = oder_reg;

    always_comb
    begin
        recip = recip_of(k_reg);
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            rbfk_pkg::S_MUL_LO:  begin mul_a = {15'b0, gamma_reg}; mul_b = dist_reg[20:0]; end
            rbfk_pkg::S_MUL_HI:  begin mul_a = {15'b0, gamma_reg}; mul_b = dist_reg[41:21]; end
            rbfk_pkg::S_TMUL_LO: begin mul_a = term_reg; mul_b = {6'b0, r30_reg[14:0]}; end
            rbfk_pkg::S_TMUL_HI: begin mul_a = term_reg; mul_b = {6'b0, r30_reg[29:15]}; end
            rbfk_pkg::S_RMUL_LO: begin mul_a = quot_reg; mul_b = recip[20:0]; end
            rbfk_pkg::S_RMUL_HI: begin mul_a = quot_reg; mul_b = {6'b0, recip[35:21]}; end
            rbfk_pkg::S_DMUL_LO: begin mul_a = {15'b0, kv_reg}; mul_b = dist_reg[20:0]; end
            rbfk_pkg::S_DMUL_HI: begin mul_a = {15'b0, kv_reg}; mul_b = dist_reg[41:21]; end
            default:             begin mul_a = '0; mul_b = '0; end
        endcase
        mul_p = mul_a * mul_b;
    end

    always_comb
    begin
        state_next = state_reg;
        dist_next  = dist_reg;
        x_next     = x_reg;
        prod_next  = prod_reg;
        n_next     = n_reg;
        r30_next   = r30_reg;
        term_next  = term_reg;
        quot_next  = quot_reg;
        k_next     = k_reg;
        sum_next   = sum_reg;
        kv_next    = kv_reg;
        ov_next    = ov_reg && !out_ch.ready;
        okv_next   = okv_reg;
        oder_next  = oder_reg;
        pop        = 1'b0;

        tfull   = {9'b0, prod_reg} + {mul_p[45:0], 15'b0};
        qfull   = {15'b0, prod_reg} + {mul_p[45:0], 21'b0};
        dfull   = {6'b0, prod_reg} + {mul_p[36:0], 21'b0} + 58'd16384;
        sum_pos = sum_reg[32] ? 32'd0 : sum_reg[31:0];
        sh      = 6'd15 + {1'b0, n_reg};
        rnd     = ({16'b0, sum_pos} + (48'd1 << (sh - 6'd1))) >> sh;

        case (state_reg)
            rbfk_pkg::S_IDLE:
            begin
                if (q_rd.valid)
                begin
                    pop        = 1'b1;
                    dist_next  = q_rd.dist2;
                    state_next = rbfk_pkg::S_MUL_LO;
                end
            end
            rbfk_pkg::S_MUL_LO:
            begin
                prod_next  = mul_p;
                state_next = rbfk_pkg::S_MUL_HI;
            end
            rbfk_pkg::S_MUL_HI:
            begin
                x_next     = {6'b0, prod_reg} + {mul_p[36:0], 21'b0};
                state_next = rbfk_pkg::S_CHECK;
            end
            rbfk_pkg::S_CHECK:
            begin
                n_next = '0;
                if (x_reg >= rbfk_pkg::X_LIMIT)
                begin
                    kv_next    = '0;
                    state_next = rbfk_pkg::S_DMUL_LO;
                end
                else
                begin
                    state_next = rbfk_pkg::S_RANGE;
                end
            end
            rbfk_pkg::S_RANGE:
            begin
                // one ln2 subtraction per cycle, n stays below 18
                if (x_reg >= rbfk_pkg::LN2_Q32)
                begin
                    x_next = x_reg - rbfk_pkg::LN2_Q32;
                    n_next = n_reg + 1'b1;
                end
                else
                begin
                    r30_next   = x_reg[31:2];
                    term_next  = rbfk_pkg::ONE_Q30;
                    sum_next   = 33'(rbfk_pkg::ONE_Q30);
                    k_next     = 4'd1;
                    state_next = rbfk_pkg::S_TMUL_LO;
                end
            end
            rbfk_pkg::S_TMUL_LO:
            begin
                prod_next  = mul_p;
                state_next = rbfk_pkg::S_TMUL_HI;
            end
            rbfk_pkg::S_TMUL_HI:
            begin
                quot_next  = tfull[60:30];
                state_next = rbfk_pkg::S_RMUL_LO;
            end
            rbfk_pkg::S_RMUL_LO:
            begin
                prod_next  = mul_p;
                state_next = rbfk_pkg::S_RMUL_HI;
            end
            rbfk_pkg::S_RMUL_HI:
            begin
                quot_next  = qfull[65:35];
                state_next = rbfk_pkg::S_ACCUM;
            end
            rbfk_pkg::S_ACCUM:
            begin
                term_next = quot_reg;
                if (k_reg[0])
                begin
                    sum_next = sum_reg - $signed({2'b0, quot_reg});
                end
                else
                begin
                    sum_next = sum_reg + $signed({2'b0, quot_reg});
                end
                if (k_reg == rbfk_pkg::LAST_TERM)
                begin
                    state_next = rbfk_pkg::S_SCALE;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = rbfk_pkg::S_TMUL_LO;
                end
            end
            rbfk_pkg::S_SCALE:
            begin
                kv_next    = rnd[15:0];
                state_next = rbfk_pkg::S_DMUL_LO;
            end
            rbfk_pkg::S_DMUL_LO:
            begin
                prod_next  = mul_p;
                state_next = rbfk_pkg::S_DMUL_HI;
            end
            rbfk_pkg::S_DMUL_HI:
            begin
                if (!ov_reg || out_ch.ready)
                begin
                    ov_next    = 1'b1;
                    okv_next   = kv_reg;
                    oder_next  = -$signed(dfull[57:15]);
                    state_next = rbfk_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = rbfk_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        dist_reg <= dist_next;
        x_reg    <= x_next;
        prod_reg <= prod_next;
        n_reg    <= n_next;
        r30_reg  <= r30_next;
        term_reg <= term_next;
        quot_reg <= quot_next;
        k_reg    <= k_next;
        sum_reg  <= sum_next;
        kv_reg   <= kv_next;
        okv_reg  <= okv_next;
        oder_reg <= oder_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rbfk_pkg::S_IDLE;
            ov_reg    <= 1'b0;
            gamma_reg <= rbfk_pkg::GAMMA_RST;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            if (cfg.valid)
            begin
                gamma_reg <= cfg.data;
            end
        end
    end

endmodule

@@ tb/sv/rbf_kernel_with_gradient_tb.sv @@
// ----------------------------------------------------------------------------
// rbf_kernel_with_gradient_tb
// Streams element pairs with random idling on both channels, predicts each
// kernel value and gamma derivative, and checks every result beat in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

class rbf_scoreboard;
    bit [15:0]        gamma_reg;
    bit [41:0]        sq_dist;
    int unsigned      pair_count;
    bit [15:0]        exp_kernel[$];
    bit signed [42:0] exp_deriv[$];
    int unsigned      errors;
    int unsigned      results_seen;

    function new();
        gamma_reg    = rbfk_pkg::GAMMA_RST;
        sq_dist      = '0;
        pair_count   = 0;
        errors       = 0;
        results_seen = 0;
    endfunction

    // exp(-x), x with 32 fraction bits, rounded half up to Q1.15
    function bit [15:0] exp_neg(bit [63:0] x);
        bit [63:0]   n;
        bit [63:0]   r;
        bit [63:0]   term;
        longint      sum;
        int unsigned sh;
        if (x >= (64'd12 << 32))
            return 16'd0;
        n    = x / 64'hB172_17F8;
        r    = x - n * 64'hB172_17F8;
        term = 64'd1 << 30;
        sum  = longint'(64'd1 << 30);
        for (int k = 1; k <= 14; k++)
        begin
            term = (term * (r >> 2)) >> 30;
            term = term / k;
            if (k % 2 == 1)
                sum -= longint'(term);
            else
                sum += longint'(term);
        end
        if (sum < 0)
            sum = 0;
        sh = 32'(n) + 15;
        return 16'((64'(sum) + (64'd1 << (sh - 1))) >> sh);
    endfunction

    function void note_pair(bit signed [15:0] a, bit signed [15:0] b, bit last);
        longint    d;
        bit [63:0] acc;
        bit [15:0] kv;
        bit [63:0] der;
        d = longint'(a) - longint'(b);
        if (pair_count < rbfk_pkg::MAX_ELEMENTS)
        begin
            acc = 64'(sq_dist) + 64'(d * d);
            sq_dist = (acc > 64'h3FF_FFFF_FFFF) ? 42'h3FF_FFFF_FFFF : acc[41:0];
            pair_count++;
        end
        if (last)
        begin
            kv  = exp_neg(64'(gamma_reg) * 64'(sq_dist));
            der = (64'(sq_dist) * kv + (64'd1 << 14)) >> 15;
            exp_kernel.push_back(kv);
            exp_deriv.push_back(43'(-der));
            sq_dist    = '0;
            pair_count = 0;
        end
    endfunction

    function void check_result(bit [15:0] kv, bit signed [42:0] der);
        results_seen++;
        if (exp_kernel.size() == 0)
        begin
            $display("%0t: unexpected result kernel=%0d deriv=%0d", $time, kv, der);
            errors++;
            return;
        end
        if (kv !== exp_kernel[0])
        begin
            $display("%0t: kernel_value expected %0d actual %0d", $time, exp_kernel[0], kv);
            errors++;
        end
        if (der !== exp_deriv[0])
        begin
            $display("%0t: gamma_derivative expected %0d actual %0d",
                     $time, exp_deriv[0], der);
            errors++;
        end
        void'(exp_kernel.pop_front());
        void'(exp_deriv.pop_front());
    endfunction
endclass

module rbf_kernel_with_gradient_tb;

    localparam int CFG_GAMMA  = 0;
    localparam int LIMIT      = 3_000_000;
    localparam int BACK_DELAY = 600;

    logic clk;
    logic rst_n;

    rbfk_in_if  in_ch();
    rbfk_out_if out_ch();
    rbfk_cfg_if cfg();

    rbf_kernel_with_gradient u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source),
        .cfg    (cfg.sink)
    );

    rbf_scoreboard sb;
    int unsigned   src_idle_pct;
    int unsigned   sink_idle_pct;
    int unsigned   cycles;
    int unsigned   vectors_sent;

    always #6 clk = ~clk;

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > LIMIT)
            begin
                $display("timeout after %0d cycles", cycles);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // result side: sample at rising edge, change ready at falling edge
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready)
                sb.check_result(out_ch.kernel_value, out_ch.gamma_derivative);
            @(negedge clk);
            out_ch.ready = ($urandom_range(99) >= sink_idle_pct);
        end
    end

    task automatic send_pair(bit [15:0] a, bit [15:0] b, bit last);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid  = 1'b1;
        in_ch.a_elem = a;
        in_ch.b_elem = b;
        in_ch.last   = last;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sb.note_pair(a, b, last);
        if (last)
            vectors_sent++;
        @(negedge clk);
        in_ch.valid = 1'b0;
    endtask

    task automatic drain();
        while (sb.exp_kernel.size() != 0)
            @(negedge clk);
        repeat (BACK_DELAY) @(negedge clk);
    endtask

    task automatic write_gamma(bit [15:0] g);
        drain();
        cfg.valid = 1'b1;
        cfg.data  = g;
        do
            @(posedge clk);
        while (!cfg.ready);
        if (CFG_GAMMA == 0)
            sb.gamma_reg = g;
        @(negedge clk);
        cfg.valid = 1'b0;
    endtask

    // random vector; mostly short, differences mostly small so kernel stays nonzero
    task automatic send_vector();
        int unsigned len;
        int unsigned mode;
        bit [15:0]   a;
        bit [15:0]   b;
        len  = ($urandom_range(9) == 0) ? $urandom_range(40, 1) : $urandom_range(6, 1);
        mode = $urandom_range(3);
        for (int i = 0; i < len; i++)
        begin
            a = 16'($urandom);
            if (mode == 0)
                b = 16'($urandom);
            else
                b = a + 16'($signed($urandom_range(2 ** (4 * mode + 1)) - 2 ** (4 * mode)));
            send_pair(a, b, i == len - 1);
        end
    endtask

    task automatic random_phase(int unsigned n_vec);
        for (int v = 0; v < n_vec; v++)
            send_vector();
    endtask

    initial
    begin
        clk           = 1'b0;
        sb            = new();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        vectors_sent  = 0;
        rst_n         = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.a_elem  = '0;
        in_ch.b_elem  = '0;
        in_ch.last    = 1'b0;
        cfg.valid     = 1'b0;
        cfg.data      = '0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: reset gamma, zero distance, field extremes
        send_pair(16'h0000, 16'h0000, 1'b1);
        send_pair(16'h7FFF, 16'h8000, 1'b1);
        send_pair(16'h8000, 16'h7FFF, 1'b1);
        send_pair(16'h1000, 16'h0000, 1'b1);
        send_pair(16'hFFFF, 16'h0000, 1'b1);
        send_pair(16'h5555, 16'hAAAA, 1'b0);
        send_pair(16'h0001, 16'h0000, 1'b1);
        write_gamma(16'd1);
        send_pair(16'h7FFF, 16'h8000, 1'b1);
        send_pair(16'h0100, 16'h0000, 1'b1);
        write_gamma(16'hFFFF);
        send_pair(16'h0001, 16'h0000, 1'b1);
        send_pair(16'h0000, 16'h0000, 1'b1);
        send_pair(16'h0010, 16'h0000, 1'b1);
        // over the element limit: the extra large pair must not count
        write_gamma(16'd256);
        for (int i = 0; i < rbfk_pkg::MAX_ELEMENTS + 1; i++)
        begin
            if (i == rbfk_pkg::MAX_ELEMENTS)
                send_pair(16'h7FFF, 16'h8000, 1'b1);
            else
                send_pair(16'h0004, 16'h0000, 1'b0);
        end

        src_idle_pct  = 6;
        sink_idle_pct = 55;
        random_phase(15);
        write_gamma(16'($urandom_range(65535, 1)));
        src_idle_pct  = 55;
        sink_idle_pct = 6;
        random_phase(10);
        drain();                   // sender holds off until all results are in
        random_phase(10);
        write_gamma(16'($urandom_range(600, 1)));
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        random_phase(15);

        drain();
        $display("%0d vectors sent, %0d results checked, gamma swept 1..65535",
                 vectors_sent, sb.results_seen);
        if (sb.errors == 0 && sb.exp_kernel.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

@@ filelist.f @@
rtl/core/rbfk_pkg.sv
rtl/core/rbfk_if.sv
rtl/core/rbfk_front.sv
rtl/core/rbfk_queue.sv
rtl/core/rbfk_back.sv
rtl/core/rbf_kernel_with_gradient.sv
tb/sv/rbf_kernel_with_gradient_tb.sv
